// ===== hw/rtl/shd_pkg.sv =====
// Shared constants, types and state encoding of the static Huffman decoder.
`default_nettype none
package shd_pkg;
    localparam int SYMBOLS    = 256;
    localparam int COUNT_BITS = 24;
    localparam int NODES      = 2 * SYMBOLS;
    localparam int IDX_W      = $clog2(NODES);
    localparam int TOT_W      = IDX_W + 1;
    localparam int SYM_W      = 8;
    localparam int PFX_W      = $clog2(COUNT_BITS + 1);
    localparam int WGT_W      = 32;
    localparam int DIM_W      = 16;
    localparam int MAX_PREFIX = COUNT_BITS - 2;
    localparam int ROOT       = NODES - 2;
    localparam int BIT_CNT_W  = 4;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    typedef enum logic [3:0] {
        S_IN_HDR,
        S_HDR,
        S_SCAN,
        S_M1,
        S_M2,
        S_M3,
        S_IN_WALK,
        S_WRD,
        S_WUSE,
        S_FLUSH_W,
        S_FLUSH_D,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load_byte;
        logic hdr_step;
        logic scan_start;
        logic scan_step;
        logic merge1;
        logic merge2;
        logic merge3;
        logic walk_step;
        logic flush;
    } t_cmd;

    typedef struct packed {
        logic hdr_err;
        logic count_done;
        logic bits_one;
        logic bits_zero;
        logic scan_end;
        logic build_last;
        logic target_zero;
        logic leaf;
        logic fin;
        logic pend_v;
        logic out_free;
    } t_sts;
endpackage
`default_nettype wire

// ===== hw/rtl/shd_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module shd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== hw/rtl/shd_ctrl.sv =====
// Sequencer: header bits, tree build scan and merge, tree walk, result flush.
`default_nettype none
module shd_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  shd_pkg::t_sts      i_sts,
    output shd_pkg::t_cmd      o_cmd,
    output logic               o_in_ready
);
    shd_pkg::t_state r_state;
    shd_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= shd_pkg::S_IN_HDR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = r_state inside {shd_pkg::S_IN_HDR, shd_pkg::S_IN_WALK, shd_pkg::S_DONE};
        case (r_state)
            shd_pkg::S_IN_HDR: begin
                if (i_in_valid) begin
                    o_cmd.load_byte = 1'b1;
                    n_state = shd_pkg::S_HDR;
                end
            end
            shd_pkg::S_HDR: begin
                o_cmd.hdr_step = 1'b1;
                if (i_sts.hdr_err) begin
                    n_state = shd_pkg::S_FLUSH_D;
                end else if (i_sts.count_done) begin
                    o_cmd.scan_start = 1'b1;
                    n_state = shd_pkg::S_SCAN;
                end else if (i_sts.bits_one) begin
                    n_state = shd_pkg::S_IN_HDR;
                end
            end
            shd_pkg::S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_end) begin
                    n_state = shd_pkg::S_M1;
                end
            end
            shd_pkg::S_M1: begin
                o_cmd.merge1 = 1'b1;
                n_state = shd_pkg::S_M2;
            end
            shd_pkg::S_M2: begin
                o_cmd.merge2 = 1'b1;
                n_state = shd_pkg::S_M3;
            end
            shd_pkg::S_M3: begin
                o_cmd.merge3 = 1'b1;
                if (!i_sts.build_last) begin
                    o_cmd.scan_start = 1'b1;
                    n_state = shd_pkg::S_SCAN;
                end else if (i_sts.target_zero) begin
                    n_state = shd_pkg::S_DONE;
                end else if (i_sts.bits_zero) begin
                    n_state = shd_pkg::S_IN_WALK;
                end else begin
                    n_state = shd_pkg::S_WRD;
                end
            end
            shd_pkg::S_IN_WALK: begin
                if (i_in_valid) begin
                    o_cmd.load_byte = 1'b1;
                    n_state = shd_pkg::S_WRD;
                end
            end
            shd_pkg::S_WRD: begin
                n_state = shd_pkg::S_WUSE;
            end
            shd_pkg::S_WUSE: begin
                // hold when a leaf must push the pending result out but the output is full
                if (!(i_sts.leaf && i_sts.pend_v && !i_sts.out_free)) begin
                    o_cmd.walk_step = 1'b1;
                    if (i_sts.leaf && i_sts.fin) begin
                        n_state = shd_pkg::S_FLUSH_D;
                    end else if (i_sts.bits_one) begin
                        n_state = shd_pkg::S_FLUSH_W;
                    end else begin
                        n_state = shd_pkg::S_WRD;
                    end
                end
            end
            shd_pkg::S_FLUSH_W: begin
                if (!i_sts.pend_v) begin
                    n_state = shd_pkg::S_IN_WALK;
                end else if (i_sts.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state = shd_pkg::S_IN_WALK;
                end
            end
            shd_pkg::S_FLUSH_D: begin
                if (!i_sts.pend_v) begin
                    n_state = shd_pkg::S_DONE;
                end else if (i_sts.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state = shd_pkg::S_DONE;
                end
            end
            shd_pkg::S_DONE: begin
                n_state = shd_pkg::S_DONE;
            end
            default: begin
                n_state = shd_pkg::S_IN_HDR;
            end
        endcase
    end
endmodule
`default_nettype wire

// ===== hw/rtl/shd_dp.sv =====
// Datapath: bit shifter, count decoder, node stores, minimum scan, walker, result registers.
`default_nettype none
module shd_dp (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  shd_pkg::t_cmd                       i_cmd,
    output shd_pkg::t_sts                       o_sts,
    input  wire logic                           i_cfg_we,
    input  wire logic                           i_cfg_index,
    input  wire logic [shd_pkg::DIM_W-1:0]      i_cfg_data,
    input  wire logic [7:0]                     i_in_byte,
    input  wire logic                           i_out_stall,
    output logic                                o_out_valid,
    output logic      [shd_pkg::SYM_W-1:0]      o_symbol,
    output logic                                o_last_in_item,
    output logic                                o_image_done,
    output logic                                o_error
);
    localparam int WR_W = shd_pkg::WGT_W + 1;
    localparam int CH_W = 2 * shd_pkg::IDX_W;

    logic [shd_pkg::DIM_W-1:0]      r_width, r_height;
    logic [2*shd_pkg::DIM_W-1:0]    r_target;
    logic [7:0]                     r_sreg;
    logic [shd_pkg::BIT_CNT_W-1:0]  r_bits_left;
    logic [shd_pkg::PFX_W-1:0]      r_prefix, r_vbl;
    logic [shd_pkg::COUNT_BITS-1:0] r_accum;
    logic [shd_pkg::IDX_W-1:0]      r_cidx;
    logic [shd_pkg::TOT_W-1:0]      r_total, r_saddr;
    logic                           r_rd_v;
    logic [shd_pkg::IDX_W-1:0]      r_rd_idx;
    logic                           r_h1, r_h2;
    logic [shd_pkg::IDX_W-1:0]      r_d1, r_d2;
    logic [shd_pkg::WGT_W-1:0]      r_m1, r_m2;
    logic [shd_pkg::IDX_W-1:0]      r_walk;
    logic [31:0]                    r_sdone;
    logic                           r_pend_v;
    logic [shd_pkg::SYM_W-1:0]      r_pend_sym;
    logic                           r_pend_done, r_pend_err;

    logic                           cur_bit;
    logic [shd_pkg::PFX_W-1:0]      pos;
    logic [shd_pkg::COUNT_BITS-1:0] accum_new;
    logic                           hdr_fin;
    logic                           w_we;
    logic [shd_pkg::IDX_W-1:0]      w_waddr;
    logic [WR_W-1:0]                w_wdata, w_rdata;
    logic [CH_W-1:0]                c_rdata;
    logic [shd_pkg::WGT_W:0]        sum;
    logic [shd_pkg::WGT_W-1:0]      sum_sat, rd_w;
    logic                           rd_removed;
    logic [shd_pkg::IDX_W-1:0]      child;
    logic [31:0]                    sdone_inc;
    logic                           push;

    assign cur_bit   = r_sreg[7];
    assign pos       = r_prefix + shd_pkg::PFX_W'(2) - r_vbl;
    assign accum_new = r_accum | (shd_pkg::COUNT_BITS'(cur_bit) << pos);
    assign hdr_fin   = (r_vbl == shd_pkg::PFX_W'(1));
    assign sum       = {1'b0, r_m1} + {1'b0, r_m2};
    assign sum_sat   = sum[shd_pkg::WGT_W] ? '1 : sum[shd_pkg::WGT_W-1:0];
    assign rd_w      = w_rdata[shd_pkg::WGT_W-1:0];
    assign rd_removed = w_rdata[shd_pkg::WGT_W];
    assign child     = cur_bit ? c_rdata[shd_pkg::IDX_W-1:0] : c_rdata[CH_W-1:shd_pkg::IDX_W];
    assign sdone_inc = r_sdone + 32'd1;
    // a new leaf pushes the result still pending from this byte out
    assign push      = i_cmd.walk_step && o_sts.leaf && r_pend_v;

    always_comb begin
        o_sts             = '0;
        o_sts.hdr_err     = (r_vbl == '0) && cur_bit
                            && (r_prefix >= shd_pkg::PFX_W'(shd_pkg::MAX_PREFIX));
        o_sts.count_done  = (r_vbl != '0) && hdr_fin
                            && (r_cidx == shd_pkg::IDX_W'(shd_pkg::SYMBOLS - 1));
        o_sts.bits_one    = (r_bits_left == shd_pkg::BIT_CNT_W'(1));
        o_sts.bits_zero   = (r_bits_left == '0);
        o_sts.scan_end    = (r_saddr == r_total) && !r_rd_v;
        o_sts.build_last  = (r_total == shd_pkg::TOT_W'(shd_pkg::NODES - 2));
        o_sts.target_zero = (r_target == '0);
        o_sts.leaf        = (child < shd_pkg::IDX_W'(shd_pkg::SYMBOLS));
        o_sts.fin         = (sdone_inc >= r_target);
        o_sts.pend_v      = r_pend_v;
        o_sts.out_free    = !o_out_valid || !i_out_stall;
    end

    // node weight store: removed flag on top of the weight
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_cidx;
        w_wdata = {1'b0, shd_pkg::WGT_W'(accum_new)};
        if (i_cmd.hdr_step && (r_vbl != '0) && hdr_fin) begin
            w_we = 1'b1;
        end else if (i_cmd.merge1) begin
            w_we    = 1'b1;
            w_waddr = r_total[shd_pkg::IDX_W-1:0];
            w_wdata = {1'b0, sum_sat};
        end else if (i_cmd.merge2) begin
            w_we    = 1'b1;
            w_waddr = r_d1;
            w_wdata = {1'b1, r_m1};
        end else if (i_cmd.merge3) begin
            w_we    = 1'b1;
            w_waddr = r_d2;
            w_wdata = {1'b1, r_m2};
        end
    end

    shd_ram #(.WIDTH(WR_W), .DEPTH(shd_pkg::NODES)) u_wgt (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_saddr[shd_pkg::IDX_W-1:0]),
        .o_rdata (w_rdata)
    );

    shd_ram #(.WIDTH(CH_W), .DEPTH(shd_pkg::NODES)) u_child (
        .i_clk   (i_clk),
        .i_we    (i_cmd.merge1),
        .i_waddr (r_total[shd_pkg::IDX_W-1:0]),
        .i_wdata ({r_d1, r_d2}),
        .i_raddr (r_walk),
        .o_rdata (c_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cfg_we) begin
            if (i_cfg_index == shd_pkg::CFG_WIDTH) begin
                r_width <= i_cfg_data;
            end else begin
                r_height <= i_cfg_data;
            end
        end
        if (!i_rst_n) begin
            r_width  <= '0;
            r_height <= '0;
        end
        r_target <= (2*shd_pkg::DIM_W)'(r_width) * (2*shd_pkg::DIM_W)'(r_height);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits_left <= '0;
            r_prefix    <= '0;
            r_vbl       <= '0;
            r_accum     <= '0;
            r_cidx      <= '0;
            r_total     <= shd_pkg::TOT_W'(shd_pkg::SYMBOLS);
            r_saddr     <= '0;
            r_rd_v      <= 1'b0;
            r_h1        <= 1'b0;
            r_h2        <= 1'b0;
            r_walk      <= shd_pkg::IDX_W'(shd_pkg::ROOT);
            r_sdone     <= '0;
            r_pend_v    <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load_byte) begin
                r_sreg      <= i_in_byte;
                r_bits_left <= shd_pkg::BIT_CNT_W'(8);
            end
            if (i_cmd.hdr_step || i_cmd.walk_step) begin
                r_sreg      <= {r_sreg[6:0], 1'b0};
                r_bits_left <= r_bits_left - shd_pkg::BIT_CNT_W'(1);
            end
            if (i_cmd.hdr_step) begin
                if (r_vbl == '0) begin
                    if (cur_bit) begin
                        if (o_sts.hdr_err) begin
                            r_pend_v    <= 1'b1;
                            r_pend_sym  <= '0;
                            r_pend_done <= 1'b0;
                            r_pend_err  <= 1'b1;
                        end else begin
                            r_prefix <= r_prefix + shd_pkg::PFX_W'(1);
                        end
                    end else begin
                        r_vbl   <= r_prefix + shd_pkg::PFX_W'(2);
                        r_accum <= '0;
                    end
                end else begin
                    r_accum <= accum_new;
                    r_vbl   <= r_vbl - shd_pkg::PFX_W'(1);
                    if (hdr_fin) begin
                        r_cidx   <= r_cidx + shd_pkg::IDX_W'(1);
                        r_prefix <= '0;
                        r_accum  <= '0;
                    end
                end
            end
            // minimum pair scan over live nodes, one read per cycle
            if (i_cmd.scan_start) begin
                r_saddr <= '0;
                r_rd_v  <= 1'b0;
                r_h1    <= 1'b0;
                r_h2    <= 1'b0;
            end else begin
                if (i_cmd.scan_step) begin
                    r_rd_v   <= (r_saddr != r_total);
                    r_rd_idx <= r_saddr[shd_pkg::IDX_W-1:0];
                    if (r_saddr != r_total) begin
                        r_saddr <= r_saddr + shd_pkg::TOT_W'(1);
                    end
                end
                if (r_rd_v && !rd_removed) begin
                    if (!r_h1 || (rd_w < r_m1)) begin
                        if (r_h1) begin
                            r_h2 <= 1'b1;
                            r_d2 <= r_d1;
                            r_m2 <= r_m1;
                        end
                        r_h1 <= 1'b1;
                        r_d1 <= r_rd_idx;
                        r_m1 <= rd_w;
                    end else if (!r_h2 || (rd_w < r_m2)) begin
                        r_h2 <= 1'b1;
                        r_d2 <= r_rd_idx;
                        r_m2 <= rd_w;
                    end
                end
            end
            if (i_cmd.merge3) begin
                r_total <= r_total + shd_pkg::TOT_W'(1);
                r_walk  <= shd_pkg::IDX_W'(shd_pkg::ROOT);
                r_sdone <= '0;
            end
            // walker and result staging
            if (i_cmd.walk_step) begin
                if (o_sts.leaf) begin
                    r_sdone     <= sdone_inc;
                    r_walk      <= shd_pkg::IDX_W'(shd_pkg::ROOT);
                    r_pend_v    <= 1'b1;
                    r_pend_sym  <= child[shd_pkg::SYM_W-1:0];
                    r_pend_done <= o_sts.fin;
                    r_pend_err  <= 1'b0;
                end else begin
                    r_walk <= child;
                end
            end
            if (i_cmd.flush) begin
                r_pend_v <= 1'b0;
            end
            if (push || i_cmd.flush) begin
                o_out_valid    <= 1'b1;
                o_symbol       <= r_pend_sym;
                o_last_in_item <= i_cmd.flush;
                o_image_done   <= r_pend_done;
                o_error        <= r_pend_err;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/static_huffman_decoder.sv =====
// Top level of the static Huffman decoder: sequencer plus datapath.
//
//  channel | direction | handshake              | beat contents
//  --------+-----------+------------------------+--------------------------------------
//  in      | input     | i_in_valid / o_in_stall | i_in_byte, bits taken MSB first
//  out     | output    | o_out_valid/ i_out_stall| o_symbol, o_last_in_item, o_image_done,
//          |           |                        | o_error
//  cfg     | input     | i_cfg_we               | i_cfg_index, i_cfg_data
//
// A header byte is accepted in S_IN_HDR and its bits are then consumed in S_HDR. The tree
// build then runs 255 merges; each is a scan over every node built so far through the
// weight RAM read port followed by three writes (S_M1 to S_M3), and no beat is taken
// during the build.
// A decode byte is accepted in S_IN_WALK; each bit then takes a child RAM read (S_WRD)
// and a branch (S_WUSE), and S_FLUSH_W hands off the last result of the byte.
// Reset is synchronous; the node RAMs need no clearing since every entry is written
// before it is read. A stalled output holds the walker when a second result is due and
// holds the hand-off at the end of a byte.
`default_nettype none
module static_huffman_decoder (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic                      i_cfg_index,
    input  wire logic [shd_pkg::DIM_W-1:0] i_cfg_data,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic [7:0]                i_in_byte,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic      [shd_pkg::SYM_W-1:0] o_symbol,
    output logic                           o_last_in_item,
    output logic                           o_image_done,
    output logic                           o_error
);
    shd_pkg::t_cmd cmd;
    shd_pkg::t_sts sts;
    logic          in_ready;

    // stall the input side whenever the sequencer is busy with a beat or the build
    assign o_in_stall = !in_ready;

    shd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_ready (in_ready)
    );

    shd_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_byte      (i_in_byte),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_symbol       (o_symbol),
        .o_last_in_item (o_last_in_item),
        .o_image_done   (o_image_done),
        .o_error        (o_error)
    );
endmodule
`default_nettype wire

// ===== hw/rtl/shd_chk.sv =====
// Port-level checker for the static Huffman decoder, bound to the top level.
`default_nettype none
module shd_chk (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      o_out_valid,
    input wire logic                      i_out_stall,
    input wire logic [shd_pkg::SYM_W-1:0] o_symbol,
    input wire logic                      o_last_in_item,
    input wire logic                      o_image_done,
    input wire logic                      o_error
);
    // a stalled result beat stays up
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result beat dropped while stalled");

    // an error beat carries no symbol and closes its byte
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_error |-> o_last_in_item && !o_image_done && (o_symbol == '0))
        else $error("malformed error beat");

    // the final symbol also closes its byte
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_image_done |-> o_last_in_item)
        else $error("image done without last marker");

    // nothing follows the final or error beat
    a_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && (o_image_done || o_error) |=> !o_out_valid)
        else $error("result after end of image");
endmodule

bind static_huffman_decoder shd_chk u_shd_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_symbol       (o_symbol),
    .o_last_in_item (o_last_in_item),
    .o_image_done   (o_image_done),
    .o_error        (o_error)
);
`default_nettype wire
